>>> hdl/deq_pkg.sv
// Shared constants and operation and status codes for the double-ended queue.
package deq_pkg;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_BACK   = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

>>> hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue held in a ring buffer.
// A result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is not stalled, set by the pointer update and
// the one write or one registered read of the storage RAM per beat.
// Reset clears the front pointer, the entry count and the output valid; the
// storage itself is not cleared, since only occupied slots are ever read.
module double_ended_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  deq_pkg::op_e                        operation_i,
  input  logic [deq_pkg::VALUE_WIDTH-1:0]     value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [deq_pkg::VALUE_WIDTH-1:0]     popped_value_o,
  output deq_pkg::status_e                    status_o,
  output logic [deq_pkg::CNT_W-1:0]           occupancy_o
);

  import deq_pkg::*;

  logic [ADDR_W-1:0]      front_q, front_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   out_valid_q;
  status_e                status_q, status_d;
  logic [CNT_W-1:0]       occ_q;
  logic                   pop_ok_q, pop_ok_d;

  logic                   accept;
  logic                   is_push;
  logic                   is_full;
  logic                   is_empty;
  logic [CNT_W-1:0]       offset;
  logic [CNT_W:0]         ring_sum;
  logic [ADDR_W-1:0]      back_pos;
  logic [ADDR_W-1:0]      front_dec;
  logic [ADDR_W-1:0]      front_inc;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_push  = (operation_i == OP_PUSH_BACK) || (operation_i == OP_PUSH_FRONT);
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  // Offset from the front: the free slot past the back for a push to the back,
  // the last occupied slot otherwise.
  assign offset   = (operation_i == OP_PUSH_BACK) ? count_q : count_q - 1'b1;
  assign ring_sum = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(offset);

  always_comb begin
    if (ring_sum >= (CNT_W + 1)'(DEPTH)) begin
      back_pos = ADDR_W'(ring_sum - (CNT_W + 1)'(DEPTH));
    end else begin
      back_pos = ADDR_W'(ring_sum);
    end
  end

  assign front_dec = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == ADDR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = ST_DONE;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = back_pos;
    rd_en    = 1'b0;
    rd_addr  = back_pos;
    if (accept) begin
      if (is_push) begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (operation_i == OP_PUSH_FRONT) begin
            front_d = front_dec;
            wr_addr = front_dec;
          end
        end
      end else begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          count_d  = count_q - 1'b1;
          if (operation_i == OP_POP_FRONT) begin
            rd_addr = front_q;
            front_d = front_inc;
          end
        end
      end
    end
  end

  deq_ram #(
    .WIDTH  (VALUE_WIDTH),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
      occ_q       <= '0;
      pop_ok_q    <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        occ_q       <= count_d;
        pop_ok_q    <= pop_ok_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_q;
  assign popped_value_o = pop_ok_q ? rd_data : '0;

  // The entry count never exceeds the storage depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // A refused push is only reported when the deque is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_FULL) |-> (occ_q == CNT_W'(DEPTH)))
    else $error("full status with deque not full");

  // A refused pop reports an empty deque and a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_EMPTY) |-> (occ_q == '0) && (popped_value_o == '0))
    else $error("empty status with entries held or nonzero value");

  // Without an accepted beat the front pointer and the entry count hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q) && $stable(front_q))
    else $error("state changed without an accepted beat");

  // The reported occupancy tracks the entry count right after a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (occ_q == count_q) && out_valid_q)
    else $error("reported occupancy differs from entry count");

endmodule

>>> hdl/deq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module deq_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> tb/sv/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue with a scoreboard class and random stalls.
`timescale 1ns / 1ps

module tb_double_ended_queue;

  import deq_pkg::*;

  typedef struct {
    logic [VALUE_WIDTH-1:0] popped;
    status_e                status;
    logic [CNT_W-1:0]       occ;
  } deque_result_t;

  class deque_scoreboard;
    logic [VALUE_WIDTH-1:0] slots [DEPTH];
    int unsigned            head;
    int unsigned            held;
    deque_result_t          awaited [$];
    int unsigned            errors;
    int unsigned            checked;
    int unsigned            full_refusals;
    int unsigned            empty_refusals;

    function new();
      head           = 0;
      held           = 0;
      errors         = 0;
      checked        = 0;
      full_refusals  = 0;
      empty_refusals = 0;
    endfunction

    function void note_beat(op_e op, logic [VALUE_WIDTH-1:0] v);
      deque_result_t r;
      r.popped = '0;
      r.status = ST_DONE;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else if (op == OP_PUSH_BACK) begin
            slots[ADDR_W'((head + held) % DEPTH)] = v;
            held++;
          end else begin
            head                = (head + DEPTH - 1) % DEPTH;
            slots[ADDR_W'(head)] = v;
            held++;
          end
        end
        default: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (op == OP_POP_BACK) begin
            r.popped = slots[ADDR_W'((head + held - 1) % DEPTH)];
            held--;
          end else begin
            r.popped = slots[ADDR_W'(head)];
            head     = (head + 1) % DEPTH;
            held--;
          end
        end
      endcase
      r.occ = CNT_W'(held);
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [VALUE_WIDTH-1:0] pv, status_e st, logic [CNT_W-1:0] occ);
      deque_result_t e;
      if (awaited.size() == 0) begin
        report("result beat arrived with no operation outstanding");
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (e.status == ST_FULL) full_refusals++;
      if (e.status == ST_EMPTY) empty_refusals++;
      if (pv !== e.popped)
        report($sformatf("popped_value %h, expected %h", pv, e.popped));
      if (st !== e.status)
        report($sformatf("status %0d, expected %0d", st, e.status));
      if (occ !== e.occ)
        report($sformatf("occupancy %0d, expected %0d", occ, e.occ));
    endtask
  endclass

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  op_e                    operation_i;
  logic [VALUE_WIDTH-1:0] value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [VALUE_WIDTH-1:0] popped_value_o;
  status_e                status_o;
  logic [CNT_W-1:0]       occupancy_o;

  deque_scoreboard sb;
  int unsigned     beats_sent;
  int unsigned     level;
  int unsigned     cycles;
  bit              quiet;

  double_ended_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles.", cycles);
      $display("FAIL double_ended_queue");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_beat(operation_i, value_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(popped_value_o, status_o, occupancy_o);
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VALUE_WIDTH'($urandom_range(0, 65535));
  endfunction

  function automatic op_e pick_op(int unsigned push_pct);
    bit front;
    front = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < push_pct) return front ? OP_PUSH_FRONT : OP_PUSH_BACK;
    return front ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned n;
      if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  task send_beat(op_e op, logic [VALUE_WIDTH-1:0] v, int unsigned gap);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    if ((op == OP_PUSH_BACK || op == OP_PUSH_FRONT) && level < DEPTH) level++;
    if ((op == OP_POP_BACK || op == OP_POP_FRONT) && level > 0) level--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task random_beat(int unsigned push_pct);
    if (beats_sent % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
    send_beat(pick_op(push_pct), pick_value(), quiet ? 0 : idle_len());
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb          = new();
    beats_sent  = 0;
    level       = 0;
    cycles      = 0;
    quiet       = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_PUSH_BACK;
    value_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pops on empty, front-pointer wrap, both ends, value extremes.
    send_beat(OP_POP_BACK,   16'hFFFF, idle_len());
    send_beat(OP_POP_FRONT,  16'h0000, idle_len());
    send_beat(OP_PUSH_BACK,  16'h0000, idle_len());
    send_beat(OP_PUSH_FRONT, 16'hFFFF, idle_len());
    send_beat(OP_PUSH_BACK,  16'hA5A5, 0);
    send_beat(OP_PUSH_FRONT, 16'h5A5A, 0);
    send_beat(OP_POP_FRONT,  16'hFFFF, idle_len());
    send_beat(OP_POP_BACK,   16'h1234, 0);
    send_beat(OP_POP_BACK,   16'h0000, idle_len());
    send_beat(OP_POP_FRONT,  16'h0000, 0);
    send_beat(OP_POP_FRONT,  16'h0000, idle_len());
    send_beat(OP_PUSH_FRONT, 16'h8000, 0);
    send_beat(OP_PUSH_BACK,  16'h0001, 0);
    send_beat(OP_PUSH_FRONT, 16'h7FFF, idle_len());
    send_beat(OP_POP_BACK,   16'h0000, 0);
    send_beat(OP_POP_BACK,   16'h0000, 0);
    send_beat(OP_POP_FRONT,  16'hFFFF, 0);
    send_beat(OP_POP_BACK,   16'h0000, idle_len());
    wait_drained();

    while (level < DEPTH) random_beat(85);
    repeat (8) random_beat(100);
    wait_drained();
    repeat (100) random_beat(50);
    while (level > 0) random_beat(15);
    repeat (8) random_beat(0);
    wait_drained();
    while (beats_sent < 950) begin
      random_beat(50);
      if (beats_sent % 150 == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d operations and checked %0d results, including a fill to %0d entries.",
             beats_sent, sb.checked, DEPTH);
    $display("Refused pushes on full: %0d, refused pops on empty: %0d, mismatches: %0d.",
             sb.full_refusals, sb.empty_refusals, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule
